[design/skf_pkg.sv]
`default_nettype none

package skf_pkg;

   localparam int unsigned FracBits    = 16;
   localparam int unsigned DivSteps    = 48;
   localparam int unsigned CsrIdxWidth = 3;

   typedef logic signed [31:0] fx_type;

   localparam fx_type FxMax = 32'sh7FFF_FFFF;
   localparam fx_type FxMin = 32'sh8000_0000;

   typedef enum logic [CsrIdxWidth-1:0] {
      CSR_PROCESS_NOISE     = 3'd0,
      CSR_MEASUREMENT_NOISE = 3'd1,
      CSR_STATE_GAIN        = 3'd2,
      CSR_CONTROL_GAIN      = 3'd3,
      CSR_MEASUREMENT_GAIN  = 3'd4
   } csr_index_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_SEED,
      ST_SEED_X,
      ST_SEED_Q,
      ST_SEED_P,
      ST_AX,
      ST_BU,
      ST_PX,
      ST_AP,
      ST_APA,
      ST_PP,
      ST_CP,
      ST_CPC0,
      ST_CPC,
      ST_D,
      ST_PC,
      ST_K,
      ST_IN,
      ST_KI,
      ST_X,
      ST_KC,
      ST_KCP,
      ST_P,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

   // floor(p / 2^16), clamped to 32 bits
   function automatic fx_type sat_mul(input logic signed [63:0] p);
      logic signed [47:0] s;
      s = p[63:FracBits];
      if (s > 48'sh0000_7FFF_FFFF) begin
         return FxMax;
      end else if (s < -48'sh0000_8000_0000) begin
         return FxMin;
      end
      return s[31:0];
   endfunction

   function automatic fx_type sat_sum(input logic signed [32:0] s);
      if (s > 33'sh0_7FFF_FFFF) begin
         return FxMax;
      end else if (s < -33'sh0_8000_0000) begin
         return FxMin;
      end
      return s[31:0];
   endfunction

   function automatic fx_type fx_add(input fx_type a, input fx_type b);
      return sat_sum({a[31], a} + {b[31], b});
   endfunction

   function automatic fx_type fx_sub(input fx_type a, input fx_type b);
      return sat_sum({a[31], a} - {b[31], b});
   endfunction

endpackage

`default_nettype wire

[design/skf_if.sv]
`default_nettype none

interface skf_req_if import skf_pkg::*;;
   logic   valid;
   logic   ready;
   fx_type measurement;
   fx_type control;

   modport source (output valid, output measurement, output control, input ready);
   modport sink   (input valid, input measurement, input control, output ready);
endinterface

interface skf_rsp_if import skf_pkg::*;;
   logic   valid;
   logic   ready;
   fx_type estimate;
   logic   fault;

   modport source (output valid, output estimate, output fault, input ready);
   modport sink   (input valid, input estimate, input fault, output ready);
endinterface

`default_nettype wire

[design/skf_div.sv]
`default_nettype none

// Restoring divider: (num * 2^16) / den, truncated toward zero, clamped to 32 bits.
// One quotient bit per cycle; den must be non-zero at start.
module skf_div import skf_pkg::*; (
   input  wire logic   clock,
   input  wire logic   reset,
   input  wire logic   start,
   input  wire fx_type num,
   input  wire fx_type den,
   output div_stat_type stat,
   output fx_type      quot
);

   localparam int unsigned CntWidth = $clog2(DivSteps);

   logic [DivSteps-1:0] quo_ff;
   logic [31:0]         rem_ff;
   logic [31:0]         den_ff;
   logic                neg_ff;
   logic [CntWidth-1:0] cnt_ff;
   logic                busy_ff;
   logic                done_ff;

   logic [31:0] num_mag;
   logic [31:0] den_mag;
   logic [32:0] trial;

   assign num_mag = num[31] ? (32'd0 - num) : num;
   assign den_mag = den[31] ? (32'd0 - den) : den;
   assign trial   = {rem_ff, quo_ff[DivSteps-1]} - {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CntWidth'(DivSteps - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= {num_mag, {FracBits{1'b0}}};
         rem_ff <= '0;
         den_ff <= den_mag;
         neg_ff <= num[31] ^ den[31];
      end else if (busy_ff) begin
         // keep the partial remainder when the trial subtraction goes negative
         if (!trial[32]) begin
            rem_ff <= trial[31:0];
            quo_ff <= {quo_ff[DivSteps-2:0], 1'b1};
         end else begin
            rem_ff <= {rem_ff[30:0], quo_ff[DivSteps-1]};
            quo_ff <= {quo_ff[DivSteps-2:0], 1'b0};
         end
      end
   end

   always_comb begin
      if (!neg_ff) begin
         quot = (quo_ff > DivSteps'(32'h7FFF_FFFF)) ? FxMax : quo_ff[31:0];
      end else begin
         quot = (quo_ff > DivSteps'(33'h1_0000_0000 >> 1)) ? FxMin
                                                            : (32'd0 - quo_ff[31:0]);
      end
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

endmodule

`default_nettype wire

[design/scalar_kalman_filter_core.sv]
`default_nettype none

// Scalar Kalman filter in signed Q16.16. Each request word carries a measurement
// and a control value; each yields one response word with the new estimate and a
// fault flag, set when a divisor was zero and the state was left as it was. The
// first word seeds the estimate and covariance. Work runs on one 32x32 multiplier
// and one radix-2 divider under a sequencer, and the request side is not ready
// until the word is finished. An update runs its multiplier and adder steps, a
// wait on the 48-step division for the gain, the closing steps, a done step and
// a return to idle. A seed runs three divisions in a row between the seed and
// done steps. A zero-divisor fault ends the word early: in the seed step on a
// seeding word, and after the gain denominator is formed otherwise. The response
// word is valid from the cycle in which the sequencer is back in ST_IDLE.
// A finished response waits in an output register, and the next request is taken
// while it waits; a response still not taken when the next word finishes holds
// the sequencer until it goes. Write the csr_ registers only while idle; indexes
// beyond measurement_gain are ignored.
module scalar_kalman_filter_core import skf_pkg::*; (
   input  wire logic                   clock,
   input  wire logic                   reset,
   skf_req_if.sink                     req_chan,
   skf_rsp_if.source                   rsp_chan,
   input  wire logic                   csr_we,
   input  wire logic [CsrIdxWidth-1:0] csr_index,
   input  wire logic [31:0]            csr_data
);

   state_type state_ff, state_in;

   logic [30:0] q_noise_ff;   // process noise R
   logic [30:0] m_noise_ff;   // measurement noise Q
   fx_type      a_ff, b_ff, c_ff;

   fx_type x_ff, p_ff;
   logic   started_ff;

   fx_type z_ff, u_ff;
   fx_type px_ff, pp_ff, k_ff, tmp_ff, den_ff;
   logic   fault_ff;

   logic signed [63:0] prod_ff;
   fx_type             msat;

   logic   rsp_valid_ff;
   fx_type rsp_estimate_ff;
   logic   rsp_fault_ff;

   logic   mul_en;
   fx_type mul_a, mul_b;
   logic   div_start;
   fx_type div_num, div_den;
   div_stat_type div_stat;
   fx_type div_quot;

   fx_type r_ext, q_ext, dval;
   logic   rsp_free;
   logic   accept;

   assign r_ext    = {1'b0, q_noise_ff};
   assign q_ext    = {1'b0, m_noise_ff};
   assign msat     = sat_mul(prod_ff);
   assign dval     = fx_add(msat, q_ext);
   assign rsp_free = !rsp_valid_ff || rsp_chan.ready;
   assign accept   = req_chan.valid && req_chan.ready;

   skf_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .stat  (div_stat),
      .quot  (div_quot)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (accept) state_in = started_ff ? ST_AX : ST_SEED;
         ST_SEED:   state_in = (c_ff == '0) ? ST_DONE : ST_SEED_X;
         ST_SEED_X: if (div_stat.done) state_in = ST_SEED_Q;
         ST_SEED_Q: if (div_stat.done) state_in = ST_SEED_P;
         ST_SEED_P: if (div_stat.done) state_in = ST_DONE;
         ST_AX:     state_in = ST_BU;
         ST_BU:     state_in = ST_PX;
         ST_PX:     state_in = ST_AP;
         ST_AP:     state_in = ST_APA;
         ST_APA:    state_in = ST_PP;
         ST_PP:     state_in = ST_CP;
         ST_CP:     state_in = ST_CPC0;
         ST_CPC0:   state_in = ST_CPC;
         ST_CPC:    state_in = ST_D;
         ST_D:      state_in = (dval == '0) ? ST_DONE : ST_PC;
         ST_PC:     state_in = ST_K;
         ST_K:      if (div_stat.done) state_in = ST_IN;
         ST_IN:     state_in = ST_KI;
         ST_KI:     state_in = ST_X;
         ST_X:      state_in = ST_KC;
         ST_KC:     state_in = ST_KCP;
         ST_KCP:    state_in = ST_P;
         ST_P:      state_in = ST_DONE;
         ST_DONE:   if (rsp_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // multiplier and divider controls
   always_comb begin
      mul_en    = 1'b0;
      mul_a     = a_ff;
      mul_b     = x_ff;
      div_start = 1'b0;
      div_num   = z_ff;
      div_den   = c_ff;
      unique case (state_ff)
         ST_SEED: begin
            div_start = (c_ff != '0);
         end
         ST_SEED_X: begin
            div_start = div_stat.done;
            div_num   = q_ext;
         end
         ST_SEED_Q: begin
            div_start = div_stat.done;
            div_num   = div_quot;
         end
         ST_AX: begin
            mul_en = 1'b1;
         end
         ST_BU: begin
            mul_en = 1'b1;
            mul_a  = b_ff;
            mul_b  = u_ff;
         end
         ST_PX: begin
            mul_en = 1'b1;
            mul_b  = p_ff;
         end
         ST_APA: begin
            mul_en = 1'b1;
            mul_b  = tmp_ff;
         end
         ST_CP: begin
            mul_en = 1'b1;
            mul_a  = c_ff;
            mul_b  = pp_ff;
         end
         ST_CPC: begin
            mul_en = 1'b1;
            mul_a  = c_ff;
            mul_b  = tmp_ff;
         end
         ST_D: begin
            mul_en = 1'b1;
            mul_a  = c_ff;
            mul_b  = pp_ff;
         end
         ST_PC: begin
            div_start = 1'b1;
            div_num   = msat;
            div_den   = den_ff;
         end
         ST_K: begin
            mul_en = div_stat.done;
            mul_a  = c_ff;
            mul_b  = px_ff;
         end
         ST_KI: begin
            mul_en = 1'b1;
            mul_a  = k_ff;
            mul_b  = tmp_ff;
         end
         ST_X: begin
            mul_en = 1'b1;
            mul_a  = k_ff;
            mul_b  = c_ff;
         end
         ST_KCP: begin
            mul_en = 1'b1;
            mul_a  = tmp_ff;
            mul_b  = pp_ff;
         end
         default: begin
         end
      endcase
   end

   assign req_chan.ready = (state_ff == ST_IDLE);

   always_ff @(posedge clock) begin
      if (mul_en) begin
         prod_ff <= mul_a * mul_b;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         started_ff   <= 1'b0;
         x_ff         <= '0;
         p_ff         <= '0;
         rsp_valid_ff <= 1'b0;
         q_noise_ff   <= 31'd65536;
         m_noise_ff   <= 31'd65536;
         a_ff         <= 32'sd65536;
         b_ff         <= '0;
         c_ff         <= 32'sd65536;
      end else begin
         state_ff <= state_in;

         if (csr_we) begin
            case (csr_index)
               CSR_PROCESS_NOISE:     q_noise_ff <= csr_data[30:0];
               CSR_MEASUREMENT_NOISE: m_noise_ff <= csr_data[30:0];
               CSR_STATE_GAIN:        a_ff       <= csr_data;
               CSR_CONTROL_GAIN:      b_ff       <= csr_data;
               CSR_MEASUREMENT_GAIN:  c_ff       <= csr_data;
               default: begin
               end
            endcase
         end

         unique case (state_ff)
            ST_SEED_X: if (div_stat.done) x_ff <= div_quot;
            ST_SEED_P: begin
               if (div_stat.done) begin
                  p_ff       <= div_quot;
                  started_ff <= 1'b1;
               end
            end
            ST_X:    x_ff <= fx_add(px_ff, msat);
            ST_P:    p_ff <= fx_sub(pp_ff, msat);
            default: begin
            end
         endcase

         // hold the response until taken
         if (state_ff == ST_DONE && rsp_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // working registers, no reset needed
   always_ff @(posedge clock) begin
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               z_ff     <= req_chan.measurement;
               u_ff     <= req_chan.control;
               fault_ff <= 1'b0;
            end
         end
         ST_SEED: if (c_ff == '0) fault_ff <= 1'b1;
         ST_BU:   tmp_ff <= msat;
         ST_PX:   px_ff  <= fx_add(tmp_ff, msat);
         ST_AP:   tmp_ff <= msat;
         ST_PP:   pp_ff  <= fx_add(msat, r_ext);
         ST_CPC0: tmp_ff <= msat;
         ST_D: begin
            den_ff <= dval;
            if (dval == '0) fault_ff <= 1'b1;
         end
         ST_K:    if (div_stat.done) k_ff <= div_quot;
         ST_IN:   tmp_ff <= fx_sub(z_ff, msat);
         ST_KC:   tmp_ff <= msat;
         default: begin
         end
      endcase
      if (state_ff == ST_DONE && rsp_free) begin
         rsp_estimate_ff <= x_ff;
         rsp_fault_ff    <= fault_ff;
      end
   end

   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.estimate = rsp_estimate_ff;
   assign rsp_chan.fault    = rsp_fault_ff;

`ifndef SYNTHESIS
   a_div_start_idle: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_stat.busy)
      else $error("divider started while busy");

   a_div_den_nonzero: assert property (@(posedge clock) disable iff (reset)
      div_start |-> (div_den != '0))
      else $error("divider started with zero divisor");

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff != ST_IDLE))
      else $error("accepted word did not start the sequencer");

   a_started_holds: assert property (@(posedge clock) disable iff (reset)
      started_ff |=> started_ff)
      else $error("started flag dropped without reset");
`endif

endmodule

`default_nettype wire

[test/skf_checker.sv]
`timescale 1ns / 1ps

module skf_checker import skf_pkg::*; (
   input  wire logic                   clock,
   input  wire logic                   reset,
   skf_req_if                          req_mon,
   skf_rsp_if                          rsp_mon,
   input  wire logic                   csr_we,
   input  wire logic [CsrIdxWidth-1:0] csr_index,
   input  wire logic [31:0]            csr_data,
   output int                          mismatches,
   output int                          outstanding
);

   typedef struct packed {
      fx_type estimate;
      logic   fault;
   } filter_word_type;

   localparam longint Top32    = 64'sd2147483647;
   localparam longint Bottom32 = -64'sd2147483648;

   fx_type noise_proc;
   fx_type noise_meas;
   fx_type gain_a;
   fx_type gain_b;
   fx_type gain_c;
   fx_type est_state;
   fx_type cov_state;
   bit     seeded;

   filter_word_type estimates_due[$];

   function automatic fx_type clamp32(input longint v);
      if (v > Top32) return FxMax;
      if (v < Bottom32) return FxMin;
      return v[31:0];
   endfunction

   // floor of the scaled product
   function automatic fx_type q_mul(input fx_type a, input fx_type b);
      longint p;
      p = longint'(a) * longint'(b);
      return clamp32(p >>> FracBits);
   endfunction

   // quotient truncated toward zero
   function automatic fx_type q_div(input fx_type n, input fx_type d);
      return clamp32((longint'(n) <<< FracBits) / longint'(d));
   endfunction

   function automatic fx_type q_add(input fx_type a, input fx_type b);
      return clamp32(longint'(a) + longint'(b));
   endfunction

   function automatic fx_type q_sub(input fx_type a, input fx_type b);
      return clamp32(longint'(a) - longint'(b));
   endfunction

   task automatic advance_filter(input fx_type z, input fx_type u, output filter_word_type r);
      fx_type px;
      fx_type pp;
      fx_type den;
      fx_type k;
      fx_type innov;
      r.fault = 1'b0;
      if (!seeded) begin
         if (gain_c == 0) begin
            r.fault = 1'b1;
         end else begin
            est_state = q_div(z, gain_c);
            cov_state = q_div(q_div(noise_meas, gain_c), gain_c);
            seeded    = 1'b1;
         end
      end else begin
         px  = q_add(q_mul(gain_a, est_state), q_mul(gain_b, u));
         pp  = q_add(q_mul(q_mul(gain_a, cov_state), gain_a), noise_proc);
         den = q_add(q_mul(q_mul(gain_c, pp), gain_c), noise_meas);
         if (den == 0) begin
            r.fault = 1'b1;
         end else begin
            k         = q_div(q_mul(pp, gain_c), den);
            innov     = q_sub(z, q_mul(gain_c, px));
            est_state = q_add(px, q_mul(k, innov));
            cov_state = q_sub(pp, q_mul(q_mul(k, gain_c), pp));
         end
      end
      r.estimate = est_state;
   endtask

   task automatic log_mismatch(input string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      mismatches++;
   endtask

   always @(posedge clock) begin
      filter_word_type want;
      if (reset) begin
         noise_proc = 32'sh0001_0000;
         noise_meas = 32'sh0001_0000;
         gain_a     = 32'sh0001_0000;
         gain_b     = '0;
         gain_c     = 32'sh0001_0000;
         est_state  = '0;
         cov_state  = '0;
         seeded     = 1'b0;
         mismatches = 0;
         estimates_due.delete();
      end else begin
         // compare first: a word leaving now belongs to an earlier request
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (estimates_due.size() == 0) begin
               log_mismatch($sformatf("response estimate=%h fault=%b with none due",
                                      rsp_mon.estimate, rsp_mon.fault));
            end else begin
               want = estimates_due.pop_front();
               if (rsp_mon.estimate !== want.estimate)
                  log_mismatch($sformatf("estimate %h, want %h",
                                         rsp_mon.estimate, want.estimate));
               if (rsp_mon.fault !== want.fault)
                  log_mismatch($sformatf("fault %b, want %b (estimate %h)",
                                         rsp_mon.fault, want.fault, want.estimate));
            end
         end
         if (csr_we) begin
            case (csr_index)
               CSR_PROCESS_NOISE:     noise_proc = {1'b0, csr_data[30:0]};
               CSR_MEASUREMENT_NOISE: noise_meas = {1'b0, csr_data[30:0]};
               CSR_STATE_GAIN:        gain_a = csr_data;
               CSR_CONTROL_GAIN:      gain_b = csr_data;
               CSR_MEASUREMENT_GAIN:  gain_c = csr_data;
               default: ;
            endcase
         end
         if (req_mon.valid && req_mon.ready) begin
            advance_filter(req_mon.measurement, req_mon.control, want);
            estimates_due.push_back(want);
         end
      end
      outstanding = estimates_due.size();
   end

endmodule

[test/tb_scalar_kalman_filter_core.sv]
`timescale 1ns / 1ps

module tb_scalar_kalman_filter_core import skf_pkg::*;;

   localparam int ItemTarget   = 1100;
   localparam int StallLimit   = 4000;
   localparam int SettleCycles = 4;
   localparam int TailCycles   = 200;

   localparam logic [CsrIdxWidth-1:0] CsrFirstSpare =
      CsrIdxWidth'(CSR_MEASUREMENT_GAIN + 1);
   localparam logic [CsrIdxWidth-1:0] CsrLastSpare  = {CsrIdxWidth{1'b1}};

   typedef enum int {
      MIX_TUNED,
      MIX_WILD,
      MIX_CORNER
   } mix_type;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   csr_we;
   logic [CsrIdxWidth-1:0] csr_index;
   logic [31:0]            csr_data;

   int mismatches;
   int outstanding;
   int idle_cycles = 0;
   int words_sent  = 0;
   bit steady_req  = 1'b0;
   bit steady_rsp  = 1'b0;
   bit rsp_fire    = 1'b0;

   skf_req_if req_chan ();
   skf_rsp_if rsp_chan ();

   scalar_kalman_filter_core uut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   skf_checker audit (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_chan),
      .rsp_mon     (rsp_chan),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_fire <= !reset && rsp_chan.valid && rsp_chan.ready;
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles == StallLimit) begin
         $display("[scalar_kalman_filter_core] ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // hold ready low for a drawn number of cycles once a response word shows up
   initial begin
      int  rsp_wait;
      bit  armed;
      rsp_wait = 0;
      armed    = 1'b0;
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_fire) armed = 1'b0;
         if (!armed && rsp_chan.valid === 1'b1) begin
            armed    = 1'b1;
            rsp_wait = steady_rsp ? 0 : $urandom_range(0, 3);
         end else if (rsp_wait > 0) begin
            rsp_wait--;
         end
         rsp_chan.ready <= (rsp_wait == 0);
      end
   end

   function automatic fx_type corner_value();
      case ($urandom_range(0, 6))
         0: return FxMax;
         1: return FxMin;
         2: return '0;
         3: return 32'sd1;
         4: return -32'sd1;
         5: return 32'sh0001_0000;
         default: return -32'sh0001_0000;
      endcase
   endfunction

   function automatic fx_type span_value(input int unsigned half);
      return fx_type'($urandom_range(0, 2 * half)) - fx_type'(half);
   endfunction

   task automatic write_reg(input logic [CsrIdxWidth-1:0] idx, input logic [31:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(negedge clock);
   endtask

   task automatic send_word(input fx_type z, input fx_type u);
      int gap;
      gap = steady_req ? 0 : $urandom_range(0, 3);
      repeat (gap) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid       <= 1'b1;
      req_chan.measurement <= z;
      req_chan.control     <= u;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      @(negedge clock);
      words_sent++;
   endtask

   // drop valid and let every due word drain before touching registers
   task automatic settle();
      req_chan.valid <= 1'b0;
      @(negedge clock);
      while (outstanding != 0) @(negedge clock);
      repeat (SettleCycles) @(negedge clock);
   endtask

   task automatic configure(input mix_type mix);
      fx_type a;
      fx_type c;
      case (mix)
         MIX_TUNED: begin
            write_reg(CSR_PROCESS_NOISE, $urandom_range(0, 65536));
            write_reg(CSR_MEASUREMENT_NOISE, $urandom_range(0, 262144));
            a = fx_type'($urandom_range(45875, 72090));
            if ($urandom_range(0, 3) == 0) a = -a;
            write_reg(CSR_STATE_GAIN, a);
            write_reg(CSR_CONTROL_GAIN, span_value(131072));
            c = fx_type'($urandom_range(16384, 262144));
            if ($urandom_range(0, 1) == 0) c = -c;
            write_reg(CSR_MEASUREMENT_GAIN, c);
         end
         MIX_WILD: begin
            write_reg(CSR_PROCESS_NOISE, $urandom());
            write_reg(CSR_MEASUREMENT_NOISE, $urandom());
            write_reg(CSR_STATE_GAIN, $urandom());
            write_reg(CSR_CONTROL_GAIN, $urandom());
            write_reg(CSR_MEASUREMENT_GAIN, $urandom());
         end
         default: begin
            write_reg(CSR_PROCESS_NOISE, corner_value());
            write_reg(CSR_MEASUREMENT_NOISE, corner_value());
            write_reg(CSR_STATE_GAIN, corner_value());
            write_reg(CSR_CONTROL_GAIN, corner_value());
            write_reg(CSR_MEASUREMENT_GAIN, corner_value());
         end
      endcase
      if ($urandom_range(0, 7) == 0)
         write_reg(CsrIdxWidth'($urandom_range(CsrFirstSpare, CsrLastSpare)), $urandom());
      csr_we <= 1'b0;
   endtask

   initial begin
      int      phase_len;
      int      pick;
      int      r;
      mix_type mix;

      reset                = 1'b1;
      csr_we               = 1'b0;
      csr_index            = '0;
      csr_data             = '0;
      req_chan.valid       = 1'b0;
      req_chan.measurement = '0;
      req_chan.control     = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // seeding with a zero measurement gain must fault and stay unseeded
      write_reg(CSR_MEASUREMENT_GAIN, 32'h0000_0000);
      csr_we <= 1'b0;
      send_word(FxMax, FxMin);
      settle();

      // seed with a negative gain so the estimate saturates; spare index ignored
      write_reg(CSR_MEASUREMENT_GAIN, 32'hFFFF_0000);
      write_reg(CSR_MEASUREMENT_NOISE, 32'h0003_0000);
      write_reg(CsrLastSpare, 32'hFFFF_FFFF);
      csr_we <= 1'b0;
      send_word(FxMin, '0);
      settle();

      write_reg(CSR_MEASUREMENT_GAIN, 32'h0001_0000);
      write_reg(CSR_STATE_GAIN, 32'h0001_0000);
      write_reg(CSR_CONTROL_GAIN, 32'h0001_0000);
      write_reg(CSR_PROCESS_NOISE, 32'h0000_8000);
      csr_we <= 1'b0;
      send_word('0, '0);
      send_word(FxMax, FxMax);
      send_word(FxMin, FxMin);
      send_word(32'sd1, -32'sd1);
      send_word(-32'sd1, 32'sd1);
      send_word(32'sh0001_0000, '0);
      send_word(FxMax, FxMin);
      settle();

      // zero gain and zero noise give a zero gain denominator
      write_reg(CSR_MEASUREMENT_NOISE, 32'h0000_0000);
      write_reg(CSR_MEASUREMENT_GAIN, 32'h0000_0000);
      csr_we <= 1'b0;
      send_word(FxMax, 32'sd1);
      send_word(-32'sh0001_0000, FxMax);
      settle();

      // gains and noises at their extremes push the intermediates into saturation
      write_reg(CSR_STATE_GAIN, FxMin);
      write_reg(CSR_CONTROL_GAIN, FxMax);
      write_reg(CSR_MEASUREMENT_GAIN, FxMax);
      write_reg(CSR_PROCESS_NOISE, 32'hFFFF_FFFF);
      write_reg(CSR_MEASUREMENT_NOISE, 32'hFFFF_FFFF);
      csr_we <= 1'b0;
      send_word(FxMax, FxMax);
      send_word(FxMin, '0);
      send_word('0, FxMin);

      while (words_sent < ItemTarget) begin
         settle();
         pick = $urandom_range(0, 9);
         mix  = (pick < 7) ? MIX_TUNED : (pick < 9) ? MIX_WILD : MIX_CORNER;
         configure(mix);
         steady_req = ($urandom_range(0, 3) == 0);
         steady_rsp = ($urandom_range(0, 3) == 0);
         phase_len  = $urandom_range(20, 60);
         repeat (phase_len) begin
            r = $urandom_range(0, 15);
            if (mix == MIX_WILD || r == 0)
               send_word($urandom(), $urandom());
            else if (mix == MIX_CORNER || r == 1)
               send_word(corner_value(), corner_value());
            else
               send_word(span_value(1 << 24), span_value(1 << 20));
         end
      end

      req_chan.valid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (TailCycles) @(negedge clock);
      if (mismatches == 0)
         $display("[scalar_kalman_filter_core] OK");
      else
         $display("[scalar_kalman_filter_core] ERROR");
      $finish;
   end

endmodule
